### rtl/dpp_pkg.sv
// Shared constants, register codes and color map for the depth pixel to point pipeline.
`default_nettype none

package dpp_pkg;

    localparam int PIX_W   = 8;
    localparam int UNIT_W  = 4;
    localparam int CFG_W   = 31;
    localparam int Z_W     = 20;
    localparam int XY_W    = 21;
    localparam int RGB_W   = 24;
    localparam int IDX_W   = 3;

    localparam int FULL_RES    = 100;
    localparam int SQ_SCALE    = 25600;
    localparam int SQ_BIAS     = 1300;
    localparam int SQ_DIV      = 2601;
    localparam int SQ_RECIP    = 1651275;
    localparam int RECIP_SHIFT = 32;

    localparam int A_W   = 33;
    localparam int D_W   = 39;
    localparam int MAG_W = 59;
    localparam int N_W   = 61;
    localparam int DV_W  = 40;
    localparam int Q_W   = 21;

    // z leaves the depth unit after 3 stages, the lateral units after 28
    localparam int Z_STAGES = 3;
    localparam int LAT      = 28;

    typedef enum logic [IDX_W-1:0] {
        REG_DEPTH_UNIT = 3'd0,
        REG_FOCAL_X    = 3'd1,
        REG_FOCAL_Y    = 3'd2,
        REG_CENTER_X   = 3'd3,
        REG_CENTER_Y   = 3'd4,
        REG_FRAME_COLS = 3'd5,
        REG_FRAME_ROWS = 3'd6
    } cfg_idx_t;

    function automatic logic [RGB_W-1:0] jet_color(input logic [7:0] k);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] k4;
        begin
            k4 = {k[5:0], 2'b00};
            r  = 8'd0;
            g  = 8'd0;
            b  = 8'd0;
            if (k < 8'd32)
            begin
                r = 8'd128 + k4;
            end
            else if (k < 8'd96)
            begin
                r = 8'd255;
                g = k4 - 8'd128;
            end
            else if (k == 8'd96)
            begin
                r = 8'd254;
                g = 8'd255;
                b = 8'd1;
            end
            else if (k < 8'd160)
            begin
                r = 8'd254 - (k4 - 8'd128);
                g = 8'd255;
                b = 8'd2 + (k4 - 8'd128);
            end
            else if (k < 8'd224)
            begin
                g = 8'd252 - (k4 - 8'd128);
                b = 8'd255;
            end
            else
            begin
                b = 8'd252 - (k4 - 8'd128);
            end
            jet_color = {r, g, b};
        end
    endfunction

endpackage

`default_nettype wire

### rtl/dpp_depth.sv
// Depth unit: linear or square-law Z in 1/256 mm, three stages.
`default_nettype none

module dpp_depth (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [dpp_pkg::PIX_W-1:0] raw,
    input  wire logic [dpp_pkg::UNIT_W-1:0] unit,
    output logic      [dpp_pkg::Z_W-1:0]   z
);
    import dpp_pkg::*;

    logic [15:0] sq;
    logic [30:0] n_next;
    logic [30:0] n_s1_reg;
    logic [30:0] n_s2_reg;
    logic [Z_W-1:0] lin_next;
    logic [Z_W-1:0] lin_s1_reg;
    logic [Z_W-1:0] lin_s2_reg;
    logic sq_s1_reg;
    logic sq_s2_reg;
    logic [51:0] p_next;
    logic [51:0] p_s2_reg;
    logic [Z_W-1:0] qe;
    logic [31:0] rem;
    logic [Z_W-1:0] z_next;
    logic [Z_W-1:0] z_reg;

    assign sq       = 16'(raw) * 16'(raw);
    assign n_next   = 31'(sq) * 31'(SQ_SCALE) + 31'(SQ_BIAS);
    assign lin_next = 20'(12'(raw) * 12'(unit)) << 8;

    assign p_next = 52'(n_s1_reg) * 52'(SQ_RECIP);

    // estimate is exact or one low
    assign qe     = p_s2_reg[RECIP_SHIFT +: Z_W];
    assign rem    = 32'(n_s2_reg) - 32'(qe) * 32'(SQ_DIV);
    assign z_next = sq_s2_reg ? ((rem >= 32'(SQ_DIV)) ? qe + 20'd1 : qe) : lin_s2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_s1_reg   <= n_next;
            lin_s1_reg <= lin_next;
            sq_s1_reg  <= (unit == '0);
            n_s2_reg   <= n_s1_reg;
            p_s2_reg   <= p_next;
            lin_s2_reg <= lin_s1_reg;
            sq_s2_reg  <= sq_s1_reg;
            z_reg      <= z_next;
        end
    end

    assign z = z_reg;

endmodule

`default_nettype wire

### rtl/dpp_lateral.sv
// Lateral unit: pinhole back-projection with a bit-per-stage rounded divider.
`default_nettype none

module dpp_lateral (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [dpp_pkg::PIX_W-1:0] pix,
    input  wire logic [dpp_pkg::CFG_W-1:0] center,
    input  wire logic [dpp_pkg::CFG_W-1:0] focal,
    input  wire logic [dpp_pkg::PIX_W-1:0] size,
    input  wire logic [dpp_pkg::Z_W-1:0]   z,
    output logic      [dpp_pkg::XY_W-1:0]  coord
);
    import dpp_pkg::*;

    localparam logic [Q_W-1:0] NEG_LIM = Q_W'(1) << (Q_W - 1);
    localparam logic [Q_W-1:0] POS_LIM = NEG_LIM - Q_W'(1);

    // stage 1
    logic [A_W-1:0] a_s1_reg;
    logic [D_W-1:0] b_s1_reg;
    logic [D_W-1:0] den_s1_reg;
    // stages 2 and 3
    logic [D_W-1:0] d_next;
    logic           neg_next;
    logic [D_W-1:0] d_s2_reg;
    logic [D_W-1:0] d_s3_reg;
    logic           neg_s2_reg;
    logic           neg_s3_reg;
    logic [D_W-1:0] den_s2_reg;
    logic [D_W-1:0] den_s3_reg;
    // stage 4
    logic [39:0]    pl_s4_reg;
    logic [38:0]    ph_s4_reg;
    logic           neg_s4_reg;
    logic [D_W-1:0] den_s4_reg;
    // stage 5
    logic [MAG_W-1:0] mag;
    logic [N_W-1:0]   num_s5_reg;
    logic [DV_W-1:0]  dv_s5_reg;
    logic             neg_s5_reg;
    logic             denz_s5_reg;
    // divider, entry 0 is stage 6
    logic [N_W-1:0]  rem_reg  [0:Q_W-1];
    logic [Q_W-1:0]  q_reg    [0:Q_W];
    logic [DV_W-1:0] dv_reg   [0:Q_W-1];
    logic            ovf_reg  [0:Q_W];
    logic            neg_reg  [0:Q_W];
    logic            denz_reg [0:Q_W];
    // output stage
    logic [Q_W-1:0]  qs;
    logic [XY_W-1:0] coord_next;
    logic [XY_W-1:0] coord_reg;

    assign neg_next = 39'(a_s1_reg) < b_s1_reg;
    assign d_next   = neg_next ? (b_s1_reg - 39'(a_s1_reg)) : (39'(a_s1_reg) - b_s1_reg);
    assign mag      = (MAG_W'(ph_s4_reg) << 20) + MAG_W'(pl_s4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_s1_reg    <= 33'(15'(pix) * 15'(FULL_RES)) << 18;
            b_s1_reg    <= 39'(center) * 39'(size);
            den_s1_reg  <= 39'(focal) * 39'(size);
            d_s2_reg    <= d_next;
            neg_s2_reg  <= neg_next;
            den_s2_reg  <= den_s1_reg;
            d_s3_reg    <= d_s2_reg;
            neg_s3_reg  <= neg_s2_reg;
            den_s3_reg  <= den_s2_reg;
            pl_s4_reg   <= 40'(z) * 40'(d_s3_reg[19:0]);
            ph_s4_reg   <= 39'(z) * 39'(d_s3_reg[38:20]);
            neg_s4_reg  <= neg_s3_reg;
            den_s4_reg  <= den_s3_reg;
            num_s5_reg  <= (N_W'(mag) << 1) + N_W'(den_s4_reg);
            dv_s5_reg   <= {den_s4_reg, 1'b0};
            neg_s5_reg  <= neg_s4_reg;
            denz_s5_reg <= (den_s4_reg == '0);
            rem_reg[0]  <= num_s5_reg;
            q_reg[0]    <= '0;
            dv_reg[0]   <= dv_s5_reg;
            ovf_reg[0]  <= num_s5_reg >= (N_W'(dv_s5_reg) << Q_W);
            neg_reg[0]  <= neg_s5_reg;
            denz_reg[0] <= denz_s5_reg;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        localparam int BIT = Q_W - 1 - k;
        logic [N_W-1:0] dsh;
        logic           take;
        assign dsh  = N_W'(dv_reg[k]) << BIT;
        assign take = rem_reg[k] >= dsh;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]    <= q_reg[k] | (take ? (Q_W'(1) << BIT) : '0);
                ovf_reg[k+1]  <= ovf_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                denz_reg[k+1] <= denz_reg[k];
            end
        end
        if (k < Q_W - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? rem_reg[k] - dsh : rem_reg[k];
                    dv_reg[k+1]  <= dv_reg[k];
                end
            end
        end
    end

    always_comb
    begin
        if (neg_reg[Q_W])
        begin
            qs = (ovf_reg[Q_W] || q_reg[Q_W] > NEG_LIM) ? NEG_LIM : q_reg[Q_W];
            coord_next = XY_W'(Q_W'(0) - qs);
        end
        else
        begin
            qs = (ovf_reg[Q_W] || q_reg[Q_W][Q_W-1]) ? POS_LIM : q_reg[Q_W];
            coord_next = XY_W'(qs);
        end
        if (denz_reg[Q_W])
        begin
            coord_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

`default_nettype wire

### rtl/depth_pixel_to_point.sv
// Throughput: one word per cycle; the whole pipeline holds while a valid result is stalled at the output.
// The lateral divider retires one quotient bit per stage, 21 stages per axis.
// Reset: rst_n async active low clears valid bits and loads register defaults.
`default_nettype none

module depth_pixel_to_point (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [dpp_pkg::PIX_W-1:0]   depth_level,
    input  wire logic [dpp_pkg::PIX_W-1:0]   pixel_col,
    input  wire logic [dpp_pkg::PIX_W-1:0]   pixel_row,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [dpp_pkg::XY_W-1:0]  point_x,
    output logic signed [dpp_pkg::XY_W-1:0]  point_y,
    output logic      [dpp_pkg::Z_W-1:0]     point_z,
    output logic      [dpp_pkg::RGB_W-1:0]   color_rgb,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dpp_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [dpp_pkg::CFG_W-1:0]   cfg_data
);
    import dpp_pkg::*;

    logic [UNIT_W-1:0] unit_reg;
    logic [CFG_W-1:0]  focal_x_reg;
    logic [CFG_W-1:0]  focal_y_reg;
    logic [CFG_W-1:0]  center_x_reg;
    logic [CFG_W-1:0]  center_y_reg;
    logic [PIX_W-1:0]  cols_reg;
    logic [PIX_W-1:0]  rows_reg;

    logic              en;
    logic [LAT-1:0]    valid_reg;
    logic [Z_W-1:0]    z;
    logic [Z_W-1:0]    z_dly_reg   [0:LAT-Z_STAGES-1];
    logic [RGB_W-1:0]  rgb_dly_reg [0:LAT-1];
    logic [XY_W-1:0]   x_coord;
    logic [XY_W-1:0]   y_coord;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg     <= '0;
            focal_x_reg  <= 31'd262144;
            focal_y_reg  <= 31'd262144;
            center_x_reg <= '0;
            center_y_reg <= '0;
            cols_reg     <= 8'd100;
            rows_reg     <= 8'd100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEPTH_UNIT: unit_reg     <= cfg_data[UNIT_W-1:0];
                REG_FOCAL_X:    focal_x_reg  <= cfg_data;
                REG_FOCAL_Y:    focal_y_reg  <= cfg_data;
                REG_CENTER_X:   center_x_reg <= cfg_data;
                REG_CENTER_Y:   center_y_reg <= cfg_data;
                REG_FRAME_COLS: cols_reg     <= cfg_data[PIX_W-1:0];
                REG_FRAME_ROWS: rows_reg     <= cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign en       = !(valid_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    dpp_depth u_depth (
        .clk  (clk),
        .en   (en),
        .raw  (depth_level),
        .unit (unit_reg),
        .z    (z)
    );

    dpp_lateral u_lat_x (
        .clk    (clk),
        .en     (en),
        .pix    (pixel_col),
        .center (center_x_reg),
        .focal  (focal_x_reg),
        .size   (cols_reg),
        .z      (z),
        .coord  (x_coord)
    );

    dpp_lateral u_lat_y (
        .clk    (clk),
        .en     (en),
        .pix    (pixel_row),
        .center (center_y_reg),
        .focal  (focal_y_reg),
        .size   (rows_reg),
        .z      (z),
        .coord  (y_coord)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_dly_reg[0]   <= z;
            rgb_dly_reg[0] <= jet_color(depth_level);
            for (int i = 1; i < LAT - Z_STAGES; i++)
            begin
                z_dly_reg[i] <= z_dly_reg[i-1];
            end
            for (int i = 1; i < LAT; i++)
            begin
                rgb_dly_reg[i] <= rgb_dly_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[LAT-1];
    assign point_x   = x_coord;
    assign point_y   = y_coord;
    assign point_z   = z_dly_reg[LAT-Z_STAGES-1];
    assign color_rgb = rgb_dly_reg[LAT-1];

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    a_zero_depth_zero_xy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && point_z == '0) |-> (point_x == '0 && point_y == '0))
        else $error("zero depth gave a nonzero lateral coordinate");

    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (point_z <= 20'd979200))
        else $error("depth out of range");

endmodule

`default_nettype wire
